@@ rtl/pp_pkg.sv @@
// Shared types and constants for the polygon perimeter block.
`default_nettype none
package pp_pkg;

	// Vertex limit and the count width it needs (count runs 0..MAX_VERTICES)
	localparam int MAX_VERTICES = 128;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int MIN_VERTICES = 3;

	// Coordinate, difference, square and root widths
	localparam int COORD_W   = 16;
	localparam int MAG_W     = 16;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUMSQ_W   = SQ_W + 1;
	localparam int RAD_W     = 35;
	localparam int ROOT_W    = 17;
	localparam int SUM_W     = 24;
	localparam int ROOT_STEPS = (RAD_W + 1) / 2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic                      last_vertex;
	} in_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] perimeter;
		status_t          status;
	} out_word_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic first_load;
		logic set_ovf;
		logic square;
		logic sel_close;
		logic sum;
		logic root_start;
		logic acc;
		logic advance;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic ovf;
		logic few;
		logic last;
		logic root_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/pp_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module pp_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pp_pkg::RAD_W-1:0]  radicand,
	output logic                           busy,
	output logic [pp_pkg::ROOT_W-1:0]      root
);
	import pp_pkg::*;

	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [RAD_W:0]   trial;
	logic             take;

	// Try subtracting the current partial root plus the bit under test
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = ({1'b0, rem_q} >= trial);

	assign busy = (bit_q != '0);
	assign root = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

	// Advance remainder and root one step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
		end else if (busy) begin
			if (take) begin
				rem_q <= rem_q - trial[RAD_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/pp_datapath.sv @@
// Vertex registers, edge length arithmetic, running sum and result register.
`default_nettype none
module pp_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pp_pkg::in_word_t  in_data,
	input  wire pp_pkg::dp_cmd_t   cmd,
	output pp_pkg::dp_stat_t       stat,
	output pp_pkg::out_word_t      out_data
);
	import pp_pkg::*;

	in_word_t                  vin_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]          count_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      ovf_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic [SUMSQ_W-1:0]        sumsq_q;
	out_word_t                 out_q;

	logic signed [COORD_W-1:0] op_x, op_y;
	logic [MAG_W-1:0]          mag_x, mag_y;
	logic                      root_busy;
	logic [ROOT_W-1:0]         root;
	logic [SUM_W:0]            acc_sum;
	status_t                   st;

	function automatic logic [MAG_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[MAG_W-1:0];
	endfunction

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			vin_q <= in_data;
		end
	end

	// Edge is previous vertex to either the new vertex or the first one
	assign op_x  = cmd.sel_close ? first_x_q : vin_q.x_coord;
	assign op_y  = cmd.sel_close ? first_y_q : vin_q.y_coord;
	assign mag_x = abs_diff(prev_x_q, op_x);
	assign mag_y = abs_diff(prev_y_q, op_y);

	// Square, then add
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= mag_x * mag_x;
			sqy_q <= mag_y * mag_y;
		end
		if (cmd.sum) begin
			sumsq_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
		end
	end

	pp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (RAD_W'(sumsq_q)),
		.busy     (root_busy),
		.root     (root)
	);

	// Saturating add of the edge length
	assign acc_sum = {1'b0, sum_q} + (SUM_W + 1)'(root);

	// Polygon state; loading a result clears it for the next polygon
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.out_load) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (cmd.first_load) begin
				first_x_q <= vin_q.x_coord;
				first_y_q <= vin_q.y_coord;
				prev_x_q  <= vin_q.x_coord;
				prev_y_q  <= vin_q.y_coord;
				count_q   <= CNT_W'(1);
			end
			if (cmd.advance) begin
				prev_x_q <= vin_q.x_coord;
				prev_y_q <= vin_q.y_coord;
				count_q  <= count_q + 1'b1;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.acc) begin
				sum_q <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
			end
		end
	end

	// Too many vertices wins over too few
	always_comb begin
		if (ovf_q) begin
			st = ST_MANY;
		end else if (count_q < CNT_W'(MIN_VERTICES)) begin
			st = ST_FEW;
		end else begin
			st = ST_OK;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status    <= st;
			out_q.perimeter <= (st == ST_OK) ? sum_q : '0;
		end
	end

	assign out_data       = out_q;
	assign stat.cnt_zero  = (count_q == '0);
	assign stat.cnt_full  = (count_q == CNT_W'(MAX_VERTICES));
	assign stat.ovf       = ovf_q;
	assign stat.few       = (count_q < CNT_W'(MIN_VERTICES));
	assign stat.last      = vin_q.last_vertex;
	assign stat.root_busy = root_busy;

endmodule
`default_nettype wire

@@ rtl/pp_ctrl.sv @@
// Sequencer for vertex intake, edge length steps and result handoff.
`default_nettype none
module pp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire pp_pkg::dp_stat_t stat,
	output pp_pkg::dp_cmd_t       cmd
);
	import pp_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DISP  = 8'b0000_0010,
		S_SUM   = 8'b0000_0100,
		S_START = 8'b0000_1000,
		S_ROOT  = 8'b0001_0000,
		S_ACC   = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   close_q, close_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		close_d = close_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISP;
				end
			end
			// Drop, start a polygon, or measure the edge to the new vertex
			S_DISP: begin
				if (stat.cnt_full) begin
					cmd.set_ovf = 1'b1;
					state_d     = stat.last ? S_FIN : S_IDLE;
				end else if (stat.cnt_zero) begin
					cmd.first_load = 1'b1;
					state_d        = stat.last ? S_FIN : S_IDLE;
				end else begin
					cmd.square = 1'b1;
					state_d    = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_START;
			end
			S_START: begin
				cmd.root_start = 1'b1;
				state_d        = S_ROOT;
			end
			S_ROOT: begin
				if (!stat.root_busy) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (close_q) begin
					state_d = S_OUT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = stat.last ? S_FIN : S_IDLE;
				end
			end
			// Errors go straight out; otherwise measure the closing edge
			S_FIN: begin
				if (stat.ovf || stat.few) begin
					state_d = S_OUT;
				end else begin
					cmd.square    = 1'b1;
					cmd.sel_close = 1'b1;
					close_d       = 1'b1;
					state_d       = S_SUM;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					close_d      = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				close_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			close_q <= close_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/polygon_perimeter.sv @@
// Top level of the polygon perimeter block.
//
// Vertices enter one word at a time as signed Q7.8 x and y. The word flagged
// last_vertex closes the polygon and yields one result word: the perimeter in
// unsigned Q16.8 (saturating at all ones) with status ok, too few vertices
// (fewer than three) or too many (more than MAX_VERTICES, extra vertices being
// dropped). On an error the perimeter reads zero. Each edge length is the
// floored square root of dx*dx + dy*dy, found by a shared unit that works
// through the radicand two bits at a time. After an accepted word the input
// stays busy through the dispatch step and, for a vertex that adds an edge,
// through the square, sum, root and accumulate steps. The last vertex then
// also measures the closing edge (skipped on an error) and loads the result
// register, a load that waits while the previous result word is not taken.
// A finished result waits in that register while the next vertex is already
// taken in.
`default_nettype none
module polygon_perimeter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pp_pkg::in_word_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pp_pkg::out_word_t      out_data
);
	import pp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pp_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

@@ rtl/pp_checker.sv @@
// Port-level checks for the polygon perimeter block, bound to its top level.
`default_nettype none
module pp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire pp_pkg::in_word_t  in_data,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire pp_pkg::out_word_t out_data
);
	import pp_pkg::*;

	// A waiting vertex word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("vertex word changed while waiting");

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FEW ||
			out_data.status == ST_MANY))
		else $error("undefined status code");

	// Error results carry a zero perimeter
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.perimeter == '0)
		else $error("error result with nonzero perimeter");

	// A taken vertex always keeps the input busy for the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a vertex was taken");

endmodule

bind polygon_perimeter pp_checker u_pp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

@@ sim/polygon_perimeter_checker.sv @@
// Checker for the polygon perimeter block: predicts every result word and compares it.
`timescale 1ns / 100ps
module polygon_perimeter_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  pp_pkg::in_word_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pp_pkg::out_word_t out_data,
	output int                errors,
	output int                pending
);
	import pp_pkg::*;

	localparam logic [SUM_W-1:0] SUM_CAP = '1;

	// Polygon under construction
	logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
	int                        held;
	logic [SUM_W-1:0]          running_sum;
	logic                      dropped;

	out_word_t expected_perims[$];
	int        mismatches = 0;

	assign errors = mismatches;

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Floor of the square root, one root bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned radicand);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root;
	endfunction

	function automatic longint unsigned edge_length(
		input logic signed [COORD_W-1:0] ax, ay, bx, by);
		longint dx;
		longint dy;
		dx = longint'(bx) - longint'(ax);
		dy = longint'(by) - longint'(ay);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		return floor_root(longint'(dx * dx + dy * dy));
	endfunction

	// Add one edge, saturating at all ones
	task automatic add_to_sum(input longint unsigned len);
		longint unsigned total;
		total = longint'(running_sum) + len;
		running_sum = (total > SUM_CAP) ? SUM_CAP : total[SUM_W-1:0];
	endtask

	task automatic clear_polygon();
		first_x     = '0;
		first_y     = '0;
		prev_x      = '0;
		prev_y      = '0;
		held        = 0;
		running_sum = '0;
		dropped     = 1'b0;
	endtask

	// Fold one vertex into the polygon; queue a result word on the last one
	task automatic absorb_vertex(input in_word_t w);
		out_word_t res;
		if (held >= MAX_VERTICES) begin
			dropped = 1'b1;
		end else if (held == 0) begin
			first_x = w.x_coord;
			first_y = w.y_coord;
			prev_x  = w.x_coord;
			prev_y  = w.y_coord;
			held    = 1;
		end else begin
			add_to_sum(edge_length(prev_x, prev_y, w.x_coord, w.y_coord));
			prev_x = w.x_coord;
			prev_y = w.y_coord;
			held++;
		end
		if (w.last_vertex) begin
			if (dropped) begin
				res.perimeter = '0;
				res.status    = ST_MANY;
			end else if (held < MIN_VERTICES) begin
				res.perimeter = '0;
				res.status    = ST_FEW;
			end else begin
				add_to_sum(edge_length(prev_x, prev_y, first_x, first_y));
				res.perimeter = running_sum;
				res.status    = ST_OK;
			end
			expected_perims.push_back(res);
			clear_polygon();
		end
	endtask

	// Compare result words first, then take the vertex of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_polygon();
			expected_perims.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_perims.size() == 0) begin
					report_mismatch($sformatf("unexpected word, perimeter %0d status %0d",
						out_data.perimeter, out_data.status));
				end else begin
					if (out_data.perimeter !== expected_perims[0].perimeter)
						report_mismatch($sformatf("perimeter %0d, expected %0d",
							out_data.perimeter, expected_perims[0].perimeter));
					if (out_data.status !== expected_perims[0].status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_data.status, expected_perims[0].status));
					void'(expected_perims.pop_front());
				end
			end
			if (in_valid && in_ready)
				absorb_vertex(in_data);
			pending <= expected_perims.size();
		end
	end

endmodule

@@ sim/polygon_perimeter_tb.sv @@
// Testbench top for the polygon perimeter block: vertex stimulus, result drain and verdict.
`timescale 1ns / 100ps
module polygon_perimeter_tb;
	import pp_pkg::*;

	localparam int TOTAL_VERTICES = 1150;
	localparam int LIMIT_CYCLES   = 600000;
	localparam int HOLD_CYCLES    = 2500;
	localparam int HOLD_AT_WORD   = 25;
	localparam int DRAIN_CYCLES   = 64;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	int errors;
	int pending;
	int sent     = 0;
	int cycles   = 0;
	int calm_in  = 0;
	int calm_out = 0;
	logic signed [COORD_W-1:0] walk_x = '0;
	logic signed [COORD_W-1:0] walk_y = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	polygon_perimeter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	polygon_perimeter_checker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Idle a random gap before each word, with occasional stretches of no idling
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	// Mix extremes, full-range values and short steps from the previous vertex
	function automatic logic signed [COORD_W-1:0] next_coord(
		inout logic signed [COORD_W-1:0] walk);
		logic signed [COORD_W-1:0] c;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			case ($urandom_range(0, 3))
				0:       c = 16'h8000;
				1:       c = 16'h7FFF;
				2:       c = 16'h0000;
				default: c = 16'hFFFF;
			endcase
		end else if (mode < 5) begin
			c = COORD_W'($urandom);
		end else begin
			c = walk + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
		end
		walk = c;
		return c;
	endfunction

	// Offer one vertex word and hold it until accepted
	task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
		int gap;
		gap = pick_gap(calm_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= '{x_coord: x, y_coord: y, last_vertex: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Alternate between the two far corners: longest possible edges
	task automatic send_zigzag(input int n);
		logic signed [COORD_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			v = i[0] ? 16'h7FFF : 16'h8000;
			send_vertex(v, v, i == n - 1);
		end
	endtask

	task automatic send_random_polygon(input int n);
		for (int i = 0; i < n; i++)
			send_vertex(next_coord(walk_x), next_coord(walk_y), i == n - 1);
	endtask

	// Result side: random stalls, one long hold-off to back up the block
	initial begin
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			gap = (taken == HOLD_AT_WORD) ? HOLD_CYCLES : pick_gap(calm_out);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Vertex side and verdict
	initial begin
		int r;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// single vertex and two vertices: too few
		send_vertex(16'h0000, 16'h0000, 1'b1);
		send_vertex(16'h7FFF, 16'h8000, 1'b0);
		send_vertex(16'h8000, 16'h7FFF, 1'b1);
		// full-span triangle
		send_vertex(16'h8000, 16'h8000, 1'b0);
		send_vertex(16'h7FFF, 16'h8000, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
		// all vertices on one point: zero perimeter
		send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
		// diagonal that rounds down
		send_vertex(16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h0100, 16'h0000, 1'b0);
		send_vertex(16'h0000, 16'h0100, 1'b1);
		// tiny square around the origin
		send_vertex(16'hFFFF, 16'hFFFF, 1'b0);
		send_vertex(16'h0001, 16'hFFFF, 1'b0);
		send_vertex(16'h0001, 16'h0001, 1'b0);
		send_vertex(16'hFFFF, 16'h0001, 1'b1);
		// toggling bit patterns
		send_vertex(16'h5555, 16'hAAAA, 1'b0);
		send_vertex(16'hAAAA, 16'h5555, 1'b0);
		send_vertex(16'h0F0F, 16'hF0F0, 1'b0);
		send_vertex(16'hF0F0, 16'h0F0F, 1'b0);
		send_vertex(16'h1234, 16'hEDCB, 1'b1);

		// exactly at the vertex limit, then past it with the last word dropped
		send_zigzag(MAX_VERTICES);
		send_zigzag(MAX_VERTICES + 3);

		// random polygons, mostly short, a few near the limit
		while (sent < TOTAL_VERTICES) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				n = $urandom_range(1, 2);
			else if (r == 6)
				n = $urandom_range(MAX_VERTICES - 2, MAX_VERTICES + 4);
			else
				n = $urandom_range(3, 12);
			send_random_polygon(n);
		end
		in_valid <= 1'b0;

		// drain outstanding words, then let the block settle
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
